FILE: design/lsh_pkg.sv
package lsh_pkg;

   localparam int COUNT_W      = 32;
   localparam int TOTAL_W      = 48;
   localparam int SAMPLE_W     = 32;
   localparam int THRESH_W     = 36;
   localparam int CAT_W        = 3;
   localparam int BIN_W        = 3;
   localparam int BINS_PER_CAT = 7;
   localparam int NUM_THRESH   = 5;
   localparam int STEP_W       = 3;

   localparam logic             MODE_ADD   = 1'b0;
   localparam logic             MODE_CLEAR = 1'b1;
   localparam logic [BIN_W-1:0] TOP_BIN    = 3'd6;
   localparam logic [BIN_W-1:0] BIN_ABOVE  = 3'd1;
   localparam logic [BIN_W-1:0] BIN_BELOW  = 3'd0;

   typedef struct packed {
      logic [COUNT_W-1:0]  count;
      logic [TOTAL_W-1:0]  total;
      logic [SAMPLE_W-1:0] max;
   } rec_type;

   // scale factors in tenths, largest first
   function automatic logic [3:0] thresh_k(input logic [STEP_W-1:0] step);
      logic [3:0] k;
      case (step)
         3'd0:    k = 4'd15;
         3'd1:    k = 4'd14;
         3'd2:    k = 4'd13;
         3'd3:    k = 4'd12;
         3'd4:    k = 4'd11;
         default: k = 4'd10;
      endcase
      return k;
   endfunction

endpackage

FILE: design/latency_stats_histogram_top.sv
// Add transfer: the record is read and updated, the one-bit-per-cycle divider forms the
// average, a threshold scan picks the bin, then the bin count is read and written back.
// Clear and out-of-range transfers go straight to the result. One item in flight; the next
// req is taken as soon as the result is in the output register, even if rsp is stalled.
// Synchronous active-high reset; all statistics read as zero after reset or a clear.
module latency_stats_histogram_top
   import lsh_pkg::*;
#(
   parameter int NUM_CATEGORIES = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_mode,
   input  logic [CAT_W-1:0]    req_category,
   input  logic [SAMPLE_W-1:0] req_sample_ticks,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_accepted,
   output logic [BIN_W-1:0]    rsp_bin,
   output logic [SAMPLE_W-1:0] rsp_average,
   output logic [SAMPLE_W-1:0] rsp_maximum,
   output logic [COUNT_W-1:0]  rsp_sample_count,
   output logic [COUNT_W-1:0]  rsp_bin_count
);

   localparam int CAT_AW    = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;
   localparam int BIN_DEPTH = NUM_CATEGORIES * BINS_PER_CAT;
   localparam int BIN_AW    = $clog2(BIN_DEPTH);
   localparam int REC_W     = $bits(rec_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REC_WAIT,
      ST_DIV,
      ST_BIN,
      ST_BIN_RD,
      ST_BIN_WAIT,
      ST_RESULT
   } state_type;

   state_type           state_ff;
   logic [CAT_W-1:0]    cat_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic                acc_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [SAMPLE_W-1:0] max_ff;
   logic [SAMPLE_W-1:0] avg_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [BIN_W-1:0]    bin_ff;
   logic [COUNT_W-1:0]  bin_count_ff;

   logic                rsp_valid_ff;
   logic                rsp_accepted_ff;
   logic [BIN_W-1:0]    rsp_bin_ff;
   logic [SAMPLE_W-1:0] rsp_average_ff;
   logic [SAMPLE_W-1:0] rsp_maximum_ff;
   logic [COUNT_W-1:0]  rsp_sample_count_ff;
   logic [COUNT_W-1:0]  rsp_bin_count_ff;

   logic                req_xfer;
   logic                in_range;
   logic                clear;
   rec_type             rec_rd;
   rec_type             rec_in;
   logic [REC_W-1:0]    rec_rd_bits;
   logic [TOTAL_W:0]    total_sum;
   logic [COUNT_W-1:0]  bin_rd;
   logic [COUNT_W-1:0]  bin_count_in;
   logic [5:0]          bin_addr_wide;
   logic [BIN_AW-1:0]   bin_addr;
   logic                div_start;
   logic                div_done;
   logic [SAMPLE_W-1:0] div_quot;
   logic [THRESH_W-1:0] thresh;
   logic [THRESH_W-1:0] limit;
   logic                hit;
   logic                out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign in_range  = {1'b0, req_category} < (CAT_W + 1)'(NUM_CATEGORIES);
   assign clear     = req_xfer && (req_mode == MODE_CLEAR);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign rec_rd = rec_type'(rec_rd_bits);

   always_comb begin
      total_sum    = {1'b0, rec_rd.total} + (TOTAL_W + 1)'(sample_ff);
      rec_in.count = (&rec_rd.count) ? rec_rd.count : rec_rd.count + COUNT_W'(1);
      rec_in.max   = (sample_ff > rec_rd.max) ? sample_ff : rec_rd.max;
      rec_in.total = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
   end

   assign div_start = (state_ff == ST_REC_WAIT);

   // sample >= floor(avg*k/10)  <=>  avg*k <= 10*sample + 9
   assign thresh = THRESH_W'(avg_ff) * THRESH_W'(thresh_k(step_ff));
   assign limit  = (THRESH_W'(sample_ff) << 3) + (THRESH_W'(sample_ff) << 1)
                   + THRESH_W'(9);
   assign hit    = (thresh <= limit);

   assign bin_addr_wide = (6'(cat_ff) << 3) - 6'(cat_ff) + 6'(bin_ff);
   assign bin_addr      = bin_addr_wide[BIN_AW-1:0];
   assign bin_count_in  = (&bin_rd) ? bin_rd : bin_rd + COUNT_W'(1);

   lsh_mem #(
      .WIDTH (REC_W),
      .DEPTH (NUM_CATEGORIES)
   ) u_rec_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (clear),
      .wr_en   (state_ff == ST_REC_WAIT),
      .wr_addr (cat_ff[CAT_AW-1:0]),
      .wr_data (REC_W'(rec_in)),
      .rd_en   (req_xfer),
      .rd_addr (req_category[CAT_AW-1:0]),
      .rd_data (rec_rd_bits)
   );

   lsh_mem #(
      .WIDTH (COUNT_W),
      .DEPTH (BIN_DEPTH)
   ) u_bin_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (clear),
      .wr_en   (state_ff == ST_BIN_WAIT),
      .wr_addr (bin_addr),
      .wr_data (bin_count_in),
      .rd_en   (state_ff == ST_BIN_RD),
      .rd_addr (bin_addr),
      .rd_data (bin_rd)
   );

   lsh_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rec_in.total),
      .divisor  (rec_in.count),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_RESULT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  cat_ff       <= req_category;
                  sample_ff    <= req_sample_ticks;
                  acc_ff       <= (req_mode == MODE_CLEAR) || in_range;
                  bin_ff       <= BIN_BELOW;
                  avg_ff       <= '0;
                  max_ff       <= '0;
                  count_ff     <= '0;
                  bin_count_ff <= '0;
                  if (req_mode == MODE_ADD && in_range) begin
                     state_ff <= ST_REC_WAIT;
                  end else begin
                     state_ff <= ST_RESULT;
                  end
               end
            end
            ST_REC_WAIT: begin
               count_ff <= rec_in.count;
               max_ff   <= rec_in.max;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (div_done) begin
                  avg_ff   <= div_quot;
                  step_ff  <= '0;
                  state_ff <= ST_BIN;
               end
            end
            ST_BIN: begin
               if (hit) begin
                  bin_ff   <= TOP_BIN - BIN_W'(step_ff);
                  state_ff <= ST_BIN_RD;
               end else if (step_ff == STEP_W'(NUM_THRESH - 1)) begin
                  bin_ff   <= (sample_ff > avg_ff) ? BIN_ABOVE : BIN_BELOW;
                  state_ff <= ST_BIN_RD;
               end else begin
                  step_ff <= step_ff + STEP_W'(1);
               end
            end
            ST_BIN_RD: begin
               state_ff <= ST_BIN_WAIT;
            end
            ST_BIN_WAIT: begin
               bin_count_ff <= bin_count_in;
               state_ff     <= ST_RESULT;
            end
            ST_RESULT: begin
               if (out_free) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_accepted_ff     <= acc_ff;
                  rsp_bin_ff          <= bin_ff;
                  rsp_average_ff      <= avg_ff;
                  rsp_maximum_ff      <= max_ff;
                  rsp_sample_count_ff <= count_ff;
                  rsp_bin_count_ff    <= bin_count_ff;
                  state_ff            <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_bin          = rsp_bin_ff;
   assign rsp_average      = rsp_average_ff;
   assign rsp_maximum      = rsp_maximum_ff;
   assign rsp_sample_count = rsp_sample_count_ff;
   assign rsp_bin_count    = rsp_bin_count_ff;

endmodule

FILE: design/lsh_mem.sv
module lsh_mem #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 8,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_raw_ff;
   logic             rd_hit_ff;

   // entries never written since reset or clear read as zero
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_raw_ff <= mem[rd_addr];
         rd_hit_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_hit_ff ? rd_raw_ff : '0;

endmodule

FILE: design/lsh_divider.sv
module lsh_divider
   import lsh_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [TOTAL_W-1:0]  dividend,
   input  logic [COUNT_W-1:0]  divisor,
   output logic                done,
   output logic [SAMPLE_W-1:0] quotient
);

   localparam int DSTEP_W = $clog2(TOTAL_W);

   logic               busy_ff;
   logic               done_ff;
   logic [DSTEP_W-1:0] step_ff;
   logic [TOTAL_W-1:0] dq_ff;
   logic [COUNT_W-1:0] rem_ff;
   logic [COUNT_W-1:0] div_ff;

   logic [COUNT_W:0]   rem_sh;
   logic [COUNT_W+1:0] diff;
   logic               ge;
   logic [COUNT_W-1:0] rem_in;

   // restoring division, one quotient bit per cycle
   assign rem_sh = {rem_ff, dq_ff[TOTAL_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, div_ff};
   assign ge     = ~diff[COUNT_W+1];
   assign rem_in = ge ? diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + DSTEP_W'(1);
            if (step_ff == DSTEP_W'(TOTAL_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dq_ff  <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         dq_ff  <= {dq_ff[TOTAL_W-2:0], ge};
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = (|dq_ff[TOTAL_W-1:SAMPLE_W]) ? '1 : dq_ff[SAMPLE_W-1:0];

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import lsh_pkg::*;

   localparam int NUM_CAT    = 5;
   localparam int LONG_HOLD  = 300;
   localparam int PHASE_ITEMS = 175;
   localparam int unsigned SCALE_TENTHS [NUM_THRESH] = '{15, 14, 13, 12, 11};
   localparam int unsigned SEND_IDLE_PCT [4] = '{0, 64, 0, 31};
   localparam int unsigned RECV_STALL_PCT [4] = '{0, 0, 64, 31};

   typedef struct packed {
      logic                mode;
      logic [CAT_W-1:0]    category;
      logic [SAMPLE_W-1:0] ticks;
   } sample_req_type;

   typedef struct packed {
      logic                accepted;
      logic [BIN_W-1:0]    bin;
      logic [SAMPLE_W-1:0] average;
      logic [SAMPLE_W-1:0] maximum;
      logic [COUNT_W-1:0]  sample_count;
      logic [COUNT_W-1:0]  bin_count;
   } stat_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_mode = MODE_ADD;
   logic [CAT_W-1:0]    req_category = '0;
   logic [SAMPLE_W-1:0] req_sample_ticks = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_accepted;
   logic [BIN_W-1:0]    rsp_bin;
   logic [SAMPLE_W-1:0] rsp_average;
   logic [SAMPLE_W-1:0] rsp_maximum;
   logic [COUNT_W-1:0]  rsp_sample_count;
   logic [COUNT_W-1:0]  rsp_bin_count;

   // predicted statistics per category
   logic [COUNT_W-1:0]  cat_count [NUM_CAT];
   logic [TOTAL_W-1:0]  cat_total [NUM_CAT];
   logic [SAMPLE_W-1:0] cat_max [NUM_CAT];
   logic [COUNT_W-1:0]  cat_bins [NUM_CAT][BINS_PER_CAT];

   sample_req_type  pending_reqs [$];
   stat_result_type expected_stats [$];
   logic [SAMPLE_W-1:0] typical_ticks [NUM_CAT];

   logic        req_taken = 1'b0;
   logic        rx_blocked = 1'b0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   event        long_hold_ev;

   int unsigned n_mismatch = 0;
   int unsigned n_taken = 0;
   int unsigned n_results = 0;
   int unsigned n_clears = 0;
   int unsigned n_ignored = 0;
   logic [BINS_PER_CAT-1:0] bins_seen = '0;

   always #2 clock = ~clock;

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      #4_000_000;
      $display("simulation failed");
      $finish;
   end

   latency_stats_histogram_top #(
      .NUM_CATEGORIES(NUM_CAT)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_category     (req_category),
      .req_sample_ticks (req_sample_ticks),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_accepted     (rsp_accepted),
      .rsp_bin          (rsp_bin),
      .rsp_average      (rsp_average),
      .rsp_maximum      (rsp_maximum),
      .rsp_sample_count (rsp_sample_count),
      .rsp_bin_count    (rsp_bin_count)
   );

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      n_mismatch++;
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   function automatic void clear_stats();
      for (int c = 0; c < NUM_CAT; c++) begin
         cat_count[c] = '0;
         cat_total[c] = '0;
         cat_max[c]   = '0;
         for (int b = 0; b < BINS_PER_CAT; b++) cat_bins[c][b] = '0;
      end
   endfunction

   function automatic stat_result_type predict_stats(sample_req_type r);
      stat_result_type     res;
      logic [TOTAL_W:0]    sum;
      logic [TOTAL_W-1:0]  quot;
      logic [SAMPLE_W-1:0] avg;
      logic [THRESH_W-1:0] thr;
      logic [BIN_W-1:0]    b;
      int                  c;
      res = '0;
      if (r.mode == MODE_CLEAR) begin
         clear_stats();
         n_clears++;
         res.accepted = 1'b1;
         return res;
      end
      if (int'(r.category) >= NUM_CAT) begin
         n_ignored++;
         return res;
      end
      c = int'(r.category);
      if (cat_count[c] != '1) cat_count[c] = cat_count[c] + COUNT_W'(1);
      if (r.ticks > cat_max[c]) cat_max[c] = r.ticks;
      sum = {1'b0, cat_total[c]} + (TOTAL_W + 1)'(r.ticks);
      cat_total[c] = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
      quot = cat_total[c] / TOTAL_W'(cat_count[c]);
      avg = (quot > {{(TOTAL_W-SAMPLE_W){1'b0}}, {SAMPLE_W{1'b1}}}) ? '1 : quot[SAMPLE_W-1:0];
      b = (r.ticks > avg) ? BIN_ABOVE : BIN_BELOW;
      for (int i = 0; i < NUM_THRESH; i++) begin
         thr = (THRESH_W'(avg) * THRESH_W'(SCALE_TENTHS[i])) / THRESH_W'(10);
         if (THRESH_W'(r.ticks) >= thr) begin
            b = TOP_BIN - BIN_W'(i);
            break;
         end
      end
      if (cat_bins[c][b] != '1) cat_bins[c][b] = cat_bins[c][b] + COUNT_W'(1);
      bins_seen[b] = 1'b1;
      res.accepted     = 1'b1;
      res.bin          = b;
      res.average      = avg;
      res.maximum      = cat_max[c];
      res.sample_count = cat_count[c];
      res.bin_count    = cat_bins[c][b];
      return res;
   endfunction

   // mostly samples spread around a per-category typical duration so every bin gets hit
   function automatic sample_req_type random_sample_req();
      sample_req_type r;
      int unsigned pick;
      logic [63:0] s;
      pick = $urandom_range(0, 99);
      r.mode     = MODE_ADD;
      r.category = CAT_W'($urandom_range(0, NUM_CAT-1));
      r.ticks    = $urandom;
      if (pick < 2) begin
         r.mode     = MODE_CLEAR;
         r.category = CAT_W'($urandom);
         for (int c = 0; c < NUM_CAT; c++) typical_ticks[c] = $urandom >> $urandom_range(0, 30);
      end else if (pick < 7) begin
         r.category = CAT_W'($urandom_range(NUM_CAT, 7));
      end else if (pick < 15) begin
         r.ticks = $urandom;
      end else if (pick < 18) begin
         r.ticks = $urandom_range(0, 1) ? '1 : '0;
      end else begin
         s = 64'(typical_ticks[r.category]) * $urandom_range(60, 170) / 100;
         r.ticks = (s > 64'hFFFF_FFFF) ? '1 : s[SAMPLE_W-1:0];
      end
      return r;
   endfunction

   task automatic queue_item(logic mode, int cat, logic [SAMPLE_W-1:0] ticks);
      pending_reqs.push_back({mode, CAT_W'(cat), ticks});
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || expected_stats.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // request driver and ready generator
   always @(negedge clock) begin
      sample_req_type nxt;
      logic           offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         offer = pending_reqs.size() != 0 &&
                 ($urandom_range(0, 99) >= send_idle_pct);
         if (offer) begin
            nxt = pending_reqs.pop_front();
            req_mode         <= nxt.mode;
            req_category     <= nxt.category;
            req_sample_ticks <= nxt.ticks;
         end
         req_valid <= offer;
      end
      rsp_ready <= !rx_blocked && ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // long output hold-off
   initial forever begin
      @(long_hold_ev);
      rx_blocked = 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      rx_blocked = 1'b0;
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      stat_result_type want;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_stats.push_back(predict_stats({req_mode, req_category, req_sample_ticks}));
            n_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            n_results++;
            if (expected_stats.size() == 0) begin
               report_mismatch("unexpected result transfer", 64'(rsp_bin), 64'(0));
            end else begin
               want = expected_stats.pop_front();
               if (rsp_accepted !== want.accepted)
                  report_mismatch("accepted", 64'(rsp_accepted), 64'(want.accepted));
               if (rsp_bin !== want.bin)
                  report_mismatch("bin", 64'(rsp_bin), 64'(want.bin));
               if (rsp_average !== want.average)
                  report_mismatch("average", 64'(rsp_average), 64'(want.average));
               if (rsp_maximum !== want.maximum)
                  report_mismatch("maximum", 64'(rsp_maximum), 64'(want.maximum));
               if (rsp_sample_count !== want.sample_count)
                  report_mismatch("sample_count", 64'(rsp_sample_count),
                                  64'(want.sample_count));
               if (rsp_bin_count !== want.bin_count)
                  report_mismatch("bin_count", 64'(rsp_bin_count), 64'(want.bin_count));
            end
         end
      end
   end

   initial begin
      clear_stats();
      for (int c = 0; c < NUM_CAT; c++) typical_ticks[c] = $urandom >> $urandom_range(0, 30);
      wait (!reset);
      @(posedge clock);

      // directed: extremes, ignored categories, and one sample aimed at each bin
      queue_item(MODE_CLEAR, 7, '1);
      queue_item(MODE_ADD, 0, '0);
      queue_item(MODE_ADD, 0, '1);
      queue_item(MODE_ADD, 5, $urandom);
      queue_item(MODE_ADD, 7, '1);
      queue_item(MODE_ADD, 1, 1000);
      queue_item(MODE_ADD, 1, 3000);
      queue_item(MODE_ADD, 2, 1000);
      queue_item(MODE_ADD, 2, 2334);
      queue_item(MODE_ADD, 3, 1000);
      queue_item(MODE_ADD, 3, 1858);
      queue_item(MODE_ADD, 4, 1000);
      queue_item(MODE_ADD, 4, 1500);
      queue_item(MODE_ADD, 1, 2400);
      queue_item(MODE_ADD, 2, 1750);
      queue_item(MODE_ADD, 3, 100);
      queue_item(MODE_CLEAR, 2, $urandom);
      queue_item(MODE_ADD, 4, '1);
      queue_item(MODE_ADD, 4, '1);

      // sender pauses until all results are back
      wait_drained();

      // output held off while requests keep coming, so the input stalls
      -> long_hold_ev;
      for (int i = 0; i < 24; i++) pending_reqs.push_back(random_sample_req());
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = SEND_IDLE_PCT[ph];
         recv_stall_pct = RECV_STALL_PCT[ph];
         for (int i = 0; i < PHASE_ITEMS; i++) pending_reqs.push_back(random_sample_req());
         while (pending_reqs.size() != 0) @(posedge clock);
      end

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      for (int i = 0; i < 60; i++) pending_reqs.push_back(random_sample_req());
      wait_drained();
      repeat (100) @(posedge clock);

      $display("%0d request transfers (%0d clears, %0d out-of-range), %0d results checked",
               n_taken, n_clears, n_ignored, n_results);
      $display("bins hit %b over four idle mixes, a %0d-cycle output hold-off and a drain pause",
               bins_seen, LONG_HOLD);
      if (n_mismatch == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/lsh_pkg.sv
design/lsh_mem.sv
design/lsh_divider.sv
design/latency_stats_histogram_top.sv
verif/tb_top.sv
